/* hw/rtl/pnp_pkg.sv */
`default_nettype none

package pnp_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 1024;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned DIFF_W  = COORD_W + 1;
	localparam int unsigned OPND_W  = COORD_W + 2;
	localparam int unsigned PROD_W  = 2 * OPND_W;
	localparam int unsigned LEN_W   = 2 * DIFF_W - 1;
	localparam int unsigned DOT_W   = LEN_W + 1;
	localparam int unsigned FRAC_W  = 17;
	localparam int unsigned DIST_W  = 35;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned DIVC_W  = 4;

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_LEN0,
		ST_LEN1,
		ST_DOT0,
		ST_DOT1,
		ST_DOT2,
		ST_CHK,
		ST_DIV,
		ST_PX,
		ST_PY,
		ST_DX,
		ST_DY,
		ST_DIST,
		ST_UPD,
		ST_STORE,
		ST_EMIT
	} pnp_state_t;

endpackage

`default_nettype wire

/* hw/rtl/polyline_nearest_position_core.sv */
// channel | signals                                              | handshake
// in      | query_x/y, vertex_x/y, first_vertex, last_vertex      | in_valid / in_ready
// out     | segment_index, segment_fraction, found, overflow      | out_valid / out_ready
//
// One item at a time. A vertex that closes a segment runs the length and dot
// products on the shared 18x18 multiplier, then the restoring divider, then
// projection and distance, before ready returns. A skipped segment stops after the
// dot products, a first or dropped vertex before them. A last vertex also loads the
// result register, which frees the input side while out_ready is low, unless
// the next last vertex finds it still full. arst_n clears the sequencer and search.
`default_nettype none

module polyline_nearest_position_core
	import pnp_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [COORD_W-1:0]  query_x,
	input  wire logic signed [COORD_W-1:0]  query_y,
	input  wire logic signed [COORD_W-1:0]  vertex_x,
	input  wire logic signed [COORD_W-1:0]  vertex_y,
	input  wire logic                       first_vertex,
	input  wire logic                       last_vertex,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [IDX_W-1:0]                segment_index,
	output logic [FRAC_W-1:0]               segment_fraction,
	output logic                            found,
	output logic                            overflow
);

	localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

	pnp_state_t state_q, state_d;

	logic signed [COORD_W-1:0] qx_q, qy_q, cx_q, cy_q, prev_x_q, prev_y_q;
	logic                      last_q, store_q;
	logic [CNT_W-1:0]          count_q;
	logic                      have_match_q, overflowed_q;
	logic [DIST_W-1:0]         min_dist_q;
	logic [IDX_W-1:0]          best_index_q;
	logic [FRAC_W-1:0]         best_fraction_q;

	logic signed [DIFF_W-1:0]  vx_q, vy_q, px_q, py_q;
	logic signed [OPND_W-1:0]  dx_q, dy_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [LEN_W-1:0]          lensq_q, rem_q;
	logic signed [DOT_W-1:0]   dot_q;
	logic [FRAC_W-1:0]         quot_q;
	logic [DIVC_W-1:0]         divc_q;
	logic [PROD_W-1:0]         dist_q;

	logic signed [OPND_W-1:0]  mul_a, mul_b, proj;
	logic [LEN_W:0]            rem2;
	logic                      div_ge, skip_seg, out_free, accept;
	logic [CNT_W+IDX_W-1:0]    seg_ext;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign rem2     = {rem_q, 1'b0};
	assign div_ge   = rem2 >= {1'b0, lensq_q};
	assign skip_seg = (lensq_q == '0) || dot_q[DOT_W-1] ||
		(dot_q[LEN_W-1:0] > lensq_q);
	assign seg_ext  = (CNT_W + IDX_W)'(count_q - CNT_W'(1));

	// truncate toward zero: arithmetic shift, then bump negative inexact values
	assign proj = prod_q[OPND_W+15:16] +
		OPND_W'(prod_q[PROD_W-1] && (prod_q[15:0] != '0));

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				if (count_q >= CNT_W'(MAX_VERTICES) || count_q == '0) state_d = ST_STORE;
				else state_d = ST_LEN0;
			end
			ST_LEN0: begin
				mul_a = OPND_W'(vx_q); mul_b = OPND_W'(vx_q);
				state_d = ST_LEN1;
			end
			ST_LEN1: begin
				mul_a = OPND_W'(vy_q); mul_b = OPND_W'(vy_q);
				state_d = ST_DOT0;
			end
			ST_DOT0: begin
				mul_a = OPND_W'(px_q); mul_b = OPND_W'(vx_q);
				state_d = ST_DOT1;
			end
			ST_DOT1: begin
				mul_a = OPND_W'(py_q); mul_b = OPND_W'(vy_q);
				state_d = ST_DOT2;
			end
			ST_DOT2: state_d = ST_CHK;
			ST_CHK: state_d = skip_seg ? ST_STORE : ST_DIV;
			ST_DIV: begin
				if (divc_q == '0) state_d = ST_PX;
			end
			ST_PX: begin
				mul_a = OPND_W'(vx_q); mul_b = {1'b0, quot_q};
				state_d = ST_PY;
			end
			ST_PY: begin
				mul_a = OPND_W'(vy_q); mul_b = {1'b0, quot_q};
				state_d = ST_DX;
			end
			ST_DX: begin
				mul_a = dx_q; mul_b = dx_q;
				state_d = ST_DY;
			end
			ST_DY: begin
				mul_a = dy_q; mul_b = dy_q;
				state_d = ST_DIST;
			end
			ST_DIST: state_d = ST_UPD;
			ST_UPD: state_d = ST_STORE;
			ST_STORE: state_d = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			have_match_q <= 1'b0;
			overflowed_q <= 1'b0;
			out_valid    <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready && state_q != ST_EMIT) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && first_vertex) begin
						count_q      <= '0;
						have_match_q <= 1'b0;
						overflowed_q <= 1'b0;
					end
				end
				ST_PREP: begin
					if (count_q >= CNT_W'(MAX_VERTICES)) overflowed_q <= 1'b1;
				end
				ST_UPD: begin
					if (!have_match_q || dist_q[DIST_W-1:0] < min_dist_q) have_match_q <= 1'b1;
				end
				ST_STORE: begin
					if (store_q) begin
						prev_x_q <= cx_q;
						prev_y_q <= cy_q;
						count_q  <= count_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						count_q      <= '0;
						have_match_q <= 1'b0;
						overflowed_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					qx_q   <= query_x;
					qy_q   <= query_y;
					cx_q   <= vertex_x;
					cy_q   <= vertex_y;
					last_q <= last_vertex;
					if (first_vertex) begin
						min_dist_q      <= '0;
						best_index_q    <= '0;
						best_fraction_q <= '0;
					end
				end
			end
			ST_PREP: begin
				store_q <= count_q < CNT_W'(MAX_VERTICES);
				vx_q <= DIFF_W'(cx_q) - DIFF_W'(prev_x_q);
				vy_q <= DIFF_W'(cy_q) - DIFF_W'(prev_y_q);
				px_q <= DIFF_W'(qx_q) - DIFF_W'(prev_x_q);
				py_q <= DIFF_W'(qy_q) - DIFF_W'(prev_y_q);
			end
			ST_LEN1: lensq_q <= prod_q[LEN_W-1:0];
			ST_DOT0: lensq_q <= lensq_q + prod_q[LEN_W-1:0];
			ST_DOT1: dot_q <= prod_q[DOT_W-1:0];
			ST_DOT2: dot_q <= dot_q + prod_q[DOT_W-1:0];
			ST_CHK: begin
				divc_q <= '1;
				if (dot_q[LEN_W-1:0] == lensq_q) begin
					quot_q <= FRAC_W'(1);
					rem_q  <= '0;
				end else begin
					quot_q <= '0;
					rem_q  <= dot_q[LEN_W-1:0];
				end
			end
			ST_DIV: begin
				divc_q <= divc_q - DIVC_W'(1);
				quot_q <= {quot_q[FRAC_W-2:0], div_ge};
				rem_q  <= div_ge ? LEN_W'(rem2 - {1'b0, lensq_q}) : rem2[LEN_W-1:0];
			end
			ST_PY: dx_q <= OPND_W'(px_q) - proj;
			ST_DX: dy_q <= OPND_W'(py_q) - proj;
			ST_DY: dist_q <= prod_q;
			ST_DIST: dist_q <= dist_q + prod_q;
			ST_UPD: begin
				if (!have_match_q || dist_q[DIST_W-1:0] < min_dist_q) begin
					min_dist_q      <= dist_q[DIST_W-1:0];
					best_index_q    <= seg_ext[IDX_W-1:0];
					best_fraction_q <= quot_q;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					segment_index    <= have_match_q ? best_index_q : '0;
					segment_fraction <= have_match_q ? best_fraction_q : '0;
					found            <= have_match_q;
					overflow         <= overflowed_q;
					min_dist_q       <= '0;
					best_index_q     <= '0;
					best_fraction_q  <= '0;
				end
			end
			default: ;
		endcase
	end

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < lensq_q)
		else $error("divider remainder not below segment length");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> segment_fraction <= FRAC_ONE)
		else $error("fraction above one");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> segment_index == '0 && segment_fraction == '0)
		else $error("position not zero without match");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond capacity");

endmodule

`default_nettype wire
